/* hdl/cfa_pkg.sv */
`timescale 1ns / 1ps
// Shared types, widths and constants for the cluster feature accumulator.
// No dependencies; every other file of the block imports this package.
package cfa_pkg;

    // Capacity of one cluster and the widths that follow from it
    localparam int MAX_POINTS = 4096;
    localparam int LOG_MAX    = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // Field widths
    localparam int COORD_W = 24;
    localparam int ATTR_W  = 16;
    localparam int CSUM_W  = COORD_W + LOG_MAX;
    localparam int ASUM_W  = ATTR_W + LOG_MAX;
    localparam int VAL_W   = 33;
    localparam int KIND_W  = 3;
    localparam int CFG_W   = 41;
    localparam int DENS_W  = 32;

    // Stream widths
    localparam int IN_W       = 3 * COORD_W + 3 * ATTR_W;
    localparam int OUT_DATA_W = ((3 * VAL_W + 7) / 8) * 8;
    localparam int OUT_USER_W = KIND_W + 1;

    // Shared multiplier and volume arithmetic
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * COORD_W;
    localparam int FULL_W = 3 * COORD_W;
    localparam int VOL_W  = 63;
    localparam logic [VOL_W-1:0] VOL_CAP = {1'b1, {(VOL_W-1){1'b0}}};

    // Density scale: mm^3 to m^3
    localparam int         SCALE_W    = 30;
    localparam logic [MUL_W-1:0] DENS_SCALE = 32'd1000000000;

    // Shared divider: dividend covers count * 1e9, divisor covers the volume
    localparam int DVD_W = CNT_W + SCALE_W;
    localparam int DVS_W = VOL_W;

    localparam logic [CFG_W-1:0] CFG_RESET = 41'd1000;

    // One point; first member sits in the top bits, so x lands lowest
    typedef struct packed {
        logic [ATTR_W-1:0]  nir;
        logic [ATTR_W-1:0]  inten;
        logic [ATTR_W-1:0]  refl;
        logic [COORD_W-1:0] z;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } t_point;

    // Accumulated cluster state, index 0 = x / reflectivity
    typedef struct packed {
        logic                          dropped;
        logic [CNT_W-1:0]              count;
        logic [2:0][ASUM_W-1:0]        asum;
        logic [2:0][COORD_W-1:0]       box_hi;
        logic [2:0][COORD_W-1:0]       box_lo;
        logic [2:0][CSUM_W-1:0]        csum;
    } t_acc;

    // Divider request
    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef enum logic [KIND_W-1:0] {
        KIND_CENTROID = 3'd0,
        KIND_BOX_MIN  = 3'd1,
        KIND_BOX_MAX  = 3'd2,
        KIND_AVERAGE  = 3'd3,
        KIND_COUNT    = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        JOB_CX, JOB_CY, JOB_CZ, JOB_AR, JOB_AI, JOB_AN, JOB_DENS
    } t_job;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_XY, S_MUL_LO, S_MUL_HI, S_MUL_CNT,
        S_VOL_SUM, S_VOL_SAT, S_VOL_FLOOR,
        S_DIV_START, S_DIV_WAIT, S_OUT
    } t_state;

    // Sign-extend a coordinate to the result width
    function automatic logic [VAL_W-1:0] sext_coord(input logic [COORD_W-1:0] v);
        return VAL_W'($signed(v));
    endfunction

endpackage

/* hdl/cfa_accum.sv */
`timescale 1ns / 1ps
// Per-point accumulator: coordinate sums, bounding box, attribute sums,
// point count and drop flag. Depends on cfa_pkg.
module cfa_accum (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  cfa_pkg::t_point i_point,
    input  logic            i_clear,
    output cfa_pkg::t_acc   o_acc
);
    import cfa_pkg::*;

    logic [2:0][CSUM_W-1:0]  r_csum;
    logic [2:0][ASUM_W-1:0]  r_asum;
    logic [2:0][COORD_W-1:0] r_box_lo;
    logic [2:0][COORD_W-1:0] r_box_hi;
    logic [CNT_W-1:0]        r_count;
    logic                    r_dropped;

    logic [2:0][COORD_W-1:0] pt_c;
    logic [2:0][ATTR_W-1:0]  pt_a;
    logic                    room;

    assign pt_c = {i_point.z, i_point.y, i_point.x};
    assign pt_a = {i_point.nir, i_point.inten, i_point.refl};
    assign room = (r_count < CNT_W'(MAX_POINTS));

    // Sums, count and drop flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_csum    <= '0;
            r_asum    <= '0;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else if (i_take) begin
            if (room) begin
                for (int i = 0; i < 3; i++) begin
                    r_csum[i] <= r_csum[i] + CSUM_W'($signed(pt_c[i]));
                    r_asum[i] <= r_asum[i] + ASUM_W'(pt_a[i]);
                end
                r_count <= r_count + 1'b1;
            end else begin
                r_dropped <= 1'b1;
            end
        end
    end

    // Bounding box, loaded by the first point of a cluster
    always_ff @(posedge i_clk) begin
        if (i_take && room) begin
            for (int i = 0; i < 3; i++) begin
                if (r_count == '0 || $signed(pt_c[i]) < $signed(r_box_lo[i])) begin
                    r_box_lo[i] <= pt_c[i];
                end
                if (r_count == '0 || $signed(pt_c[i]) > $signed(r_box_hi[i])) begin
                    r_box_hi[i] <= pt_c[i];
                end
            end
        end
    end

    assign o_acc.csum    = r_csum;
    assign o_acc.asum    = r_asum;
    assign o_acc.box_lo  = r_box_lo;
    assign o_acc.box_hi  = r_box_hi;
    assign o_acc.count   = r_count;
    assign o_acc.dropped = r_dropped;

endmodule

/* hdl/cfa_mul.sv */
`timescale 1ns / 1ps
// Shared unsigned multiplier with a registered product.
// Depends on cfa_pkg.
module cfa_mul (
    input  logic                            i_clk,
    input  logic [cfa_pkg::MUL_W-1:0]       i_a,
    input  logic [cfa_pkg::MUL_W-1:0]       i_b,
    output logic [2*cfa_pkg::MUL_W-1:0]     o_prod
);
    import cfa_pkg::*;

    logic [2*MUL_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= (2*MUL_W)'(i_a) * (2*MUL_W)'(i_b);
    end

    assign o_prod = r_prod;

endmodule

/* hdl/cfa_div.sv */
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on cfa_pkg.
module cfa_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  cfa_pkg::t_div_req          i_req,
    output logic                       o_done,
    output logic [cfa_pkg::DVD_W-1:0]  o_quot
);
    import cfa_pkg::*;

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  r_q;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;
    logic           ge;

    // Shift in the next dividend bit and try the subtract
    assign trial = {r_rem, r_q[DVD_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = (trial >= {1'b0, r_dvs});

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == STEP_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath: quotient bits shift into the dividend register
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            r_q   <= {r_q[DVD_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

/* hdl/cluster_feature_accumulator.sv */
`timescale 1ns / 1ps
// Top level of the cluster feature accumulator: sequencer, volume and density
// datapath, output register. Depends on cfa_pkg, cfa_accum, cfa_mul, cfa_div.
//
// Usage
//   Points of one cluster arrive on the s_axis channel, one per transfer;
//   s_axis_tlast marks the closing point. Ordinary points are absorbed one
//   per cycle. After the closing point the block drops s_axis_tready and
//   runs the volume through the shared 32x32 multiplier (4 products), then
//   seven divisions (centroid x/y/z, three averages, density) through the
//   shared one-bit-per-cycle divider, one division after another. The
//   first result shows on m_axis once the divisions are done; the five
//   results follow back to back as m_axis_tready allows, kind in
//   m_axis_tuser, the fifth with m_axis_tlast. Points of the next cluster are
//   accepted again once the fifth result sits in the output register.
//   A stalled receiver holds the output register and the sequencer; nothing
//   is dropped. Points past capacity are discarded and flagged.
//   min_volume is to be written through i_cfg_wr_en / i_cfg_wr_data while
//   idle; the block does not enforce this. Reset (synchronous, active low)
//   empties the cluster and sets min_volume to 1000.
module cluster_feature_accumulator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [cfa_pkg::CFG_W-1:0]        i_cfg_wr_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // point_x, point_y, point_z, reflect_value, intensity_value, nir_value
    input  logic [cfa_pkg::IN_W-1:0]         s_axis_tdata,
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // value_a, value_b, value_c, zero padding
    output logic [cfa_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // result_kind, overflow
    output logic [cfa_pkg::OUT_USER_W-1:0]   m_axis_tuser,
    output logic                             m_axis_tlast
);
    import cfa_pkg::*;

    t_state r_state, n_state;

    logic [CFG_W-1:0]   r_min_volume;
    logic [CFG_W-1:0]   floor_v;

    t_point             in_pt;
    logic               take;
    logic               acc_clear;
    t_acc               acc;

    logic [2:0][COORD_W-1:0] span;
    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [2*MUL_W-1:0] prod;

    t_div_req           div_req;
    logic               div_start;
    logic               div_done;
    logic [DVD_W-1:0]   div_quot;
    logic               div_neg;
    logic [1:0]         axis;
    logic [CSUM_W-1:0]  csum_sel;
    logic [CSUM_W-1:0]  csum_mag;

    logic [PROD_W-1:0]  r_pxy;
    logic [PROD_W-1:0]  r_vol_lo;
    logic [PROD_W-1:0]  r_vol_hi;
    logic [FULL_W-1:0]  r_vol_full;
    logic [VOL_W-1:0]   r_vol;
    logic [DVD_W-1:0]   r_dens_num;
    t_job               r_job;
    logic [2:0][COORD_W-1:0] r_cent;
    logic [2:0][ATTR_W-1:0]  r_avg;
    logic [DENS_W-1:0]  r_dens;
    logic [COORD_W-1:0] cent_val;

    t_kind              r_kind;
    logic               load_out;
    logic               r_out_valid;
    logic [VAL_W-1:0]   r_out_a, r_out_b, r_out_c;
    logic [VAL_W-1:0]   n_out_a, n_out_b, n_out_c;
    logic [KIND_W-1:0]  r_out_kind;
    logic               r_out_last, n_out_last;
    logic               r_out_ovf;

    assign in_pt         = t_point'(s_axis_tdata);
    assign s_axis_tready = (r_state == S_IDLE);
    assign take          = s_axis_tvalid && s_axis_tready;
    assign floor_v       = (r_min_volume == '0) ? CFG_W'(1) : r_min_volume;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_volume <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            r_min_volume <= i_cfg_wr_data;
        end
    end

    cfa_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_point (in_pt),
        .i_clear (acc_clear),
        .o_acc   (acc)
    );

    // Box extents; the true difference always fits the coordinate width
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            span[i] = acc.box_hi[i] - acc.box_lo[i];
        end
    end

    cfa_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Divider operands by job
    always_comb begin
        case (r_job)
            JOB_CX, JOB_AR: axis = 2'd0;
            JOB_CY, JOB_AI: axis = 2'd1;
            JOB_CZ, JOB_AN: axis = 2'd2;
            default:        axis = 2'd0;
        endcase
        csum_sel = acc.csum[axis];
        div_neg  = csum_sel[CSUM_W-1];
        csum_mag = div_neg ? (~csum_sel + 1'b1) : csum_sel;

        div_req.start = div_start;
        case (r_job)
            JOB_CX, JOB_CY, JOB_CZ: begin
                div_req.dividend = DVD_W'(csum_mag);
                div_req.divisor  = DVS_W'(acc.count);
            end
            JOB_AR, JOB_AI, JOB_AN: begin
                div_req.dividend = DVD_W'(acc.asum[axis]);
                div_req.divisor  = DVS_W'(acc.count);
            end
            default: begin
                div_req.dividend = r_dens_num;
                div_req.divisor  = r_vol;
            end
        endcase
    end

    cfa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer next state and controls
    always_comb begin
        n_state   = r_state;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        load_out  = 1'b0;
        acc_clear = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (take && s_axis_tlast) begin
                    n_state = S_MUL_XY;
                end
            end
            S_MUL_XY: begin
                mul_a   = MUL_W'(span[0]);
                mul_b   = MUL_W'(span[1]);
                n_state = S_MUL_LO;
            end
            S_MUL_LO: begin
                mul_a   = MUL_W'(prod[COORD_W-1:0]);
                mul_b   = MUL_W'(span[2]);
                n_state = S_MUL_HI;
            end
            S_MUL_HI: begin
                mul_a   = MUL_W'(r_pxy[PROD_W-1:COORD_W]);
                mul_b   = MUL_W'(span[2]);
                n_state = S_MUL_CNT;
            end
            S_MUL_CNT: begin
                mul_a   = MUL_W'(acc.count);
                mul_b   = DENS_SCALE;
                n_state = S_VOL_SUM;
            end
            S_VOL_SUM:   n_state = S_VOL_SAT;
            S_VOL_SAT:   n_state = S_VOL_FLOOR;
            S_VOL_FLOOR: n_state = S_DIV_START;
            S_DIV_START: begin
                div_start = 1'b1;
                n_state   = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    n_state = (r_job == JOB_DENS) ? S_OUT : S_DIV_START;
                end
            end
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    load_out = 1'b1;
                    if (r_kind == KIND_COUNT) begin
                        acc_clear = 1'b1;
                        n_state   = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Volume and quotient registers
    assign cent_val = div_neg ? (~div_quot[COORD_W-1:0] + 1'b1) : div_quot[COORD_W-1:0];

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_MUL_LO:  r_pxy    <= prod[PROD_W-1:0];
            S_MUL_HI:  r_vol_lo <= prod[PROD_W-1:0];
            S_MUL_CNT: r_vol_hi <= prod[PROD_W-1:0];
            S_VOL_SUM: begin
                r_dens_num <= prod[DVD_W-1:0];
                r_vol_full <= {r_vol_hi, {COORD_W{1'b0}}} + FULL_W'(r_vol_lo);
            end
            S_VOL_SAT: begin
                r_vol <= (r_vol_full > FULL_W'(VOL_CAP)) ? VOL_CAP
                                                          : r_vol_full[VOL_W-1:0];
            end
            S_VOL_FLOOR: begin
                if (r_vol < VOL_W'(floor_v)) begin
                    r_vol <= VOL_W'(floor_v);
                end
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    case (r_job)
                        JOB_CX, JOB_CY, JOB_CZ: r_cent[axis] <= cent_val;
                        JOB_AR, JOB_AI, JOB_AN: r_avg[axis]  <= div_quot[ATTR_W-1:0];
                        default: begin
                            r_dens <= (|div_quot[DVD_W-1:DENS_W]) ? '1
                                                                  : div_quot[DENS_W-1:0];
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    // Job and result counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job  <= JOB_CX;
            r_kind <= KIND_CENTROID;
        end else begin
            if (r_state == S_IDLE) begin
                r_job <= JOB_CX;
            end else if (r_state == S_DIV_WAIT && div_done && r_job != JOB_DENS) begin
                r_job <= t_job'(r_job + 3'd1);
            end
            if (load_out) begin
                r_kind <= (r_kind == KIND_COUNT) ? KIND_CENTROID
                                                 : t_kind'(r_kind + 3'd1);
            end
        end
    end

    // Result selection
    always_comb begin
        n_out_last = 1'b0;
        case (r_kind)
            KIND_CENTROID: begin
                n_out_a = sext_coord(r_cent[0]);
                n_out_b = sext_coord(r_cent[1]);
                n_out_c = sext_coord(r_cent[2]);
            end
            KIND_BOX_MIN: begin
                n_out_a = sext_coord(acc.box_lo[0]);
                n_out_b = sext_coord(acc.box_lo[1]);
                n_out_c = sext_coord(acc.box_lo[2]);
            end
            KIND_BOX_MAX: begin
                n_out_a = sext_coord(acc.box_hi[0]);
                n_out_b = sext_coord(acc.box_hi[1]);
                n_out_c = sext_coord(acc.box_hi[2]);
            end
            KIND_AVERAGE: begin
                n_out_a = VAL_W'(r_avg[0]);
                n_out_b = VAL_W'(r_avg[1]);
                n_out_c = VAL_W'(r_avg[2]);
            end
            KIND_COUNT: begin
                n_out_a    = VAL_W'(acc.count);
                n_out_b    = VAL_W'(r_dens);
                n_out_c    = '0;
                n_out_last = 1'b1;
            end
            default: begin
                n_out_a = '0;
                n_out_b = '0;
                n_out_c = '0;
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_a    <= n_out_a;
            r_out_b    <= n_out_b;
            r_out_c    <= n_out_c;
            r_out_kind <= r_kind;
            r_out_last <= n_out_last;
            r_out_ovf  <= acc.dropped;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-3*VAL_W){1'b0}}, r_out_c, r_out_b, r_out_a};
    assign m_axis_tuser  = {r_out_ovf, r_out_kind};
    assign m_axis_tlast  = r_out_last;

endmodule

/* hdl/cfa_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for cluster_feature_accumulator, bound to the top level.
// Depends on cfa_pkg and cluster_feature_accumulator.
module cfa_port_checks (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic                             s_axis_tlast,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [cfa_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic [cfa_pkg::OUT_USER_W-1:0]   m_axis_tuser,
    input  logic                             m_axis_tlast
);
    import cfa_pkg::*;

    // A closing point stops intake while the results are computed
    a_close_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input still ready after closing point");

    // Only the count result closes a cluster
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser[KIND_W-1:0] == KIND_COUNT)))
        else $error("tlast does not match count result");

    // Results of a cluster run in kind order without gaps
    a_kind_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast
        |=> m_axis_tvalid
            && (m_axis_tuser[KIND_W-1:0] == $past(m_axis_tuser[KIND_W-1:0]) + 3'd1))
        else $error("result kind out of order");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind cluster_feature_accumulator cfa_port_checks u_cfa_checker (.*);
